// ===== rtl/bmds_pkg.sv =====
// ============================================================================
// bmds_pkg
// Shared types and constants of the multiplexed display scanner.
// ============================================================================
package bmds_pkg;

    localparam int CMD_W      = 2;
    localparam int DIGIT_W    = 4;
    localparam int PLANE_W    = 3;
    localparam int WORD_W     = 24;
    localparam int BASE_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SWAP  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_TICKS  = 1'b0,
        REG_DOT_PATTERN = 1'b1
    } t_cfg_reg;

    // slot start request handed from the command stage to the output stage
    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
        logic [PLANE_W-1:0] plane;
        logic               blank;
        logic               blink;
    } t_emit;

endpackage

// ===== rtl/bam_multiplex_display_scanner.sv =====
// ============================================================================
// bam_multiplex_display_scanner
// Double-buffered bit-angle-modulation scanner for a multiplexed display.
// ============================================================================
// Takes one command transfer per clock unless stalled: a tick, a write of one
// word into the hidden buffer, or a buffer swap. The tick that starts a slot
// emits one result, the active word for the current digit and plane, which is
// registered in the frame store's read port and then in the output register.
// Writes and swaps never emit. The slot then lasts base_ticks << plane ticks,
// at least one; planes step first, then digits. Both buffers live in one RAM
// of 2 x DIGITS x PLANES words; a valid flag per entry, cleared by reset,
// makes never-written entries read as zero, so no clearing pass is needed
// after reset. The input side stalls only when the output register is full
// and the sink holds tready low. Configuration (base_ticks, dot_pattern) is
// for the user to write only while idle; the block does not enforce it.
// ============================================================================
module bam_multiplex_display_scanner
    import bmds_pkg::*;
#(
    parameter int DIGITS = 9,
    parameter int PLANES = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [3:0] digit_sel, [6:4] plane_sel, [30:7] word_in, [31] blank,
    // [32] blink, [39:33] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    // stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [23:0] frame_word, [27:24] digit_now, [30:28] plane_now, [31] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // config write port: index 0 base_ticks, 1 dot_pattern
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int ENTRIES = 2 * DIGITS * PLANES;
    localparam int AW      = $clog2(ENTRIES);

    logic [BASE_W-1:0] r_base_ticks;
    logic [WORD_W-1:0] r_dot_pattern;

    logic               w_accept;
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [WORD_W-1:0]  w_ram_wdata;
    logic               w_ram_re;
    logic [AW-1:0]      w_ram_raddr;
    logic [WORD_W-1:0]  w_ram_rdata;
    t_emit              w_emit;
    logic               w_ent_valid;
    logic [WORD_W-1:0]  w_frame_word;
    logic [DIGIT_W-1:0] w_digit_now;
    logic [PLANE_W-1:0] w_plane_now;

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ticks  <= BASE_W'(1);
            r_dot_pattern <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_BASE_TICKS:  r_base_ticks  <= i_cfg_wdata[BASE_W-1:0];
                REG_DOT_PATTERN: r_dot_pattern <= i_cfg_wdata[WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // transfer on the input side
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // ---- command decode, counters, addressing
    bmds_ctrl #(
        .DIGITS (DIGITS),
        .PLANES (PLANES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_cmd        (i_s_axis_tuser),
        .i_digit_sel  (i_s_axis_tdata[3:0]),
        .i_plane_sel  (i_s_axis_tdata[6:4]),
        .i_word       (i_s_axis_tdata[30:7]),
        .i_blank      (i_s_axis_tdata[31]),
        .i_blink      (i_s_axis_tdata[32]),
        .i_base_ticks (r_base_ticks),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .o_emit       (w_emit),
        .o_ent_valid  (w_ent_valid)
    );

    // ---- frame store, both halves
    bmds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // ---- read return, blanking, output register
    bmds_out #(
        .DIGITS (DIGITS)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_emit        (w_emit),
        .i_ent_valid   (w_ent_valid),
        .i_rd_data     (w_ram_rdata),
        .i_dot_pattern (r_dot_pattern),
        .o_in_ready    (o_s_axis_tready),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_word        (w_frame_word),
        .o_digit       (w_digit_now),
        .o_plane       (w_plane_now)
    );

    assign o_m_axis_tdata = {1'b0, w_plane_now, w_digit_now, w_frame_word};

endmodule

// ===== rtl/bmds_ram.sv =====
// ============================================================================
// bmds_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module bmds_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 108,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bmds_ctrl.sv =====
// ============================================================================
// bmds_ctrl
// Command decode, scan counters, slot countdown and frame store addressing.
// ============================================================================
module bmds_ctrl
    import bmds_pkg::*;
#(
    parameter int DIGITS = 9,
    parameter int PLANES = 6,
    localparam int ENTRIES = 2 * DIGITS * PLANES,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [DIGIT_W-1:0] i_digit_sel,
    input  logic [PLANE_W-1:0] i_plane_sel,
    input  logic [WORD_W-1:0]  i_word,
    input  logic               i_blank,
    input  logic               i_blink,
    input  logic [BASE_W-1:0]  i_base_ticks,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [WORD_W-1:0]  o_ram_wdata,
    output logic               o_ram_re,
    output logic [AW-1:0]      o_ram_raddr,
    output t_emit              o_emit,
    output logic               o_ent_valid
);

    localparam int HALF = DIGITS * PLANES;
    localparam int CW   = BASE_W + PLANES - 1;

    logic               r_active;
    logic [DIGIT_W-1:0] r_digit;
    logic [PLANE_W-1:0] r_plane;
    logic [CW-1:0]      r_countdown;
    logic [ENTRIES-1:0] r_valid;

    logic               n_active;
    logic [DIGIT_W-1:0] n_digit;
    logic [PLANE_W-1:0] n_plane;
    logic [CW-1:0]      n_countdown;
    logic [ENTRIES-1:0] n_valid;

    t_cmd          w_cmd;
    logic          w_in_range;
    logic          w_we;
    logic          w_emit;
    logic [CW-1:0] w_len;
    logic [CW-1:0] w_reload;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;

    assign w_cmd = t_cmd'(i_cmd);

    assign w_in_range = ({1'b0, i_digit_sel} < (DIGIT_W + 1)'(DIGITS)) &&
                        ({1'b0, i_plane_sel} < (PLANE_W + 1)'(PLANES));

    // active half is read, hidden half is written
    assign w_raddr = AW'(32'(r_active) * HALF + 32'(r_digit) * PLANES + 32'(r_plane));
    assign w_waddr = AW'(32'(!r_active) * HALF + 32'(i_digit_sel) * PLANES
                         + 32'(i_plane_sel));

    assign w_len    = CW'(i_base_ticks) << r_plane;
    assign w_reload = (w_len == '0) ? '0 : w_len - CW'(1);

    always_comb begin
        w_we        = 1'b0;
        w_emit      = 1'b0;
        n_active    = r_active;
        n_digit     = r_digit;
        n_plane     = r_plane;
        n_countdown = r_countdown;
        n_valid     = r_valid;
        if (i_accept) begin
            unique case (w_cmd)
                CMD_TICK: begin
                    if (r_countdown != '0) begin
                        n_countdown = r_countdown - CW'(1);
                    end else begin
                        w_emit      = 1'b1;
                        n_countdown = w_reload;
                        if (r_plane == PLANE_W'(PLANES - 1)) begin
                            n_plane = '0;
                            n_digit = (r_digit == DIGIT_W'(DIGITS - 1)) ? '0
                                                                         : r_digit + 1'b1;
                        end else begin
                            n_plane = r_plane + 1'b1;
                        end
                    end
                end
                CMD_WRITE: begin
                    if (w_in_range) begin
                        w_we             = 1'b1;
                        n_valid[w_waddr] = 1'b1;
                    end
                end
                CMD_SWAP: begin
                    n_active = !r_active;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_digit     <= '0;
            r_plane     <= '0;
            r_countdown <= '0;
            r_valid     <= '0;
        end else begin
            r_active    <= n_active;
            r_digit     <= n_digit;
            r_plane     <= n_plane;
            r_countdown <= n_countdown;
            r_valid     <= n_valid;
        end
    end

    assign o_ram_we    = w_we;
    assign o_ram_waddr = w_waddr;
    assign o_ram_wdata = i_word;
    assign o_ram_re    = w_emit;
    assign o_ram_raddr = w_raddr;

    // never-written entries read as zero
    assign o_ent_valid = r_valid[w_raddr];

    assign o_emit.valid = w_emit;
    assign o_emit.digit = r_digit;
    assign o_emit.plane = r_plane;
    assign o_emit.blank = i_blank;
    assign o_emit.blink = i_blink;

endmodule

// ===== rtl/bmds_out.sv =====
// ============================================================================
// bmds_out
// Read-return stage and output register; applies blanking and the blink dot.
// ============================================================================
module bmds_out
    import bmds_pkg::*;
#(
    parameter int DIGITS = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_emit              i_emit,
    input  logic               i_ent_valid,
    input  logic [WORD_W-1:0]  i_rd_data,
    input  logic [WORD_W-1:0]  i_dot_pattern,
    output logic               o_in_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WORD_W-1:0]  o_word,
    output logic [DIGIT_W-1:0] o_digit,
    output logic [PLANE_W-1:0] o_plane
);

    t_emit              r_s1;
    logic               r_s1_ent;
    logic               r_o_valid;
    logic [WORD_W-1:0]  r_o_word;
    logic [DIGIT_W-1:0] r_o_digit;
    logic [PLANE_W-1:0] r_o_plane;

    logic              w_move;
    logic [WORD_W-1:0] w_word;

    assign w_move     = !r_o_valid || i_ready;
    assign o_in_ready = !r_s1.valid || w_move;

    always_comb begin
        if (r_s1.blank) begin
            w_word = (r_s1.blink && r_s1.digit == DIGIT_W'(DIGITS - 1)) ? i_dot_pattern
                                                                         : '0;
        end else begin
            w_word = r_s1_ent ? i_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1 <= i_emit;
            end
            if (w_move) begin
                r_o_valid <= r_s1.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_ent <= i_ent_valid;
        end
        if (w_move && r_s1.valid) begin
            r_o_word  <= w_word;
            r_o_digit <= r_s1.digit;
            r_o_plane <= r_s1.plane;
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;
    assign o_digit = r_o_digit;
    assign o_plane = r_o_plane;

endmodule

// ===== rtl/bmds_checker.sv =====
// ============================================================================
// bmds_checker
// Port-level checks of the scanner, bound to the top level.
// ============================================================================
module bmds_checker
    import bmds_pkg::*;
#(
    parameter int DIGITS = 9,
    parameter int PLANES = 6
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata
);

    // result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    // emitted slot indexes stay inside the scan range
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ({1'b0, o_m_axis_tdata[27:24]} < (DIGIT_W + 1)'(DIGITS)) &&
            ({1'b0, o_m_axis_tdata[30:28]} < (PLANE_W + 1)'(PLANES)))
        else $error("digit or plane index out of range");

    // input side only backs up behind a stalled, full output register
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind bam_multiplex_display_scanner bmds_checker #(
    .DIGITS (DIGITS),
    .PLANES (PLANES)
) u_bmds_checker (.*);

// ===== tb/bam_multiplex_display_scanner_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bam_multiplex_display_scanner_test
// Self-checking bench for the double-buffered BAM display scanner.
// ============================================================================
// Commands stream in (tick, hidden-buffer write, buffer swap, plus the unused
// code), and every command transfer the block takes is run through a local
// scanner model that tracks both frame buffers, the active half, the digit and
// plane counters and the slot countdown. Each slot start it predicts goes into
// a queue; every result transfer is checked field by field against the oldest
// entry. Settings of base_ticks and dot_pattern change between phases, only
// once the block has gone quiet, including base_ticks of zero and 65535 and
// dot patterns of all zeros and all ones.
// ============================================================================
module bam_multiplex_display_scanner_test;
    import bmds_pkg::*;

    localparam int DIGITS       = 9;
    localparam int PLANES       = 6;
    localparam int CLK_PERIOD   = 12;
    localparam int RST_CYCLES   = 8;
    localparam int PIPE_LAT     = 2;        // tick to result, in clock edges
    localparam int LIMIT_CYCLES = 200_000;  // run limit, in clock cycles

    // code outside t_cmd: the block must swallow it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [DIGIT_W-1:0] digit;
        logic [PLANE_W-1:0] plane;
        logic [WORD_W-1:0]  word;
        logic               blank;
        logic               blink;
    } t_cmd_item;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic [DIGIT_W-1:0] digit;
        logic [PLANE_W-1:0] plane;
    } t_slot;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [3:0] digit_sel, [6:4] plane_sel, [30:7] word_in, [31] blank,
    // [32] blink, [39:33] zero
    logic [S_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    // [1:0] command
    logic [CMD_W-1:0]      i_s_axis_tuser  = CMD_TICK;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [23:0] frame_word, [27:24] digit_now, [30:28] plane_now, [31] zero
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr      = REG_BASE_TICKS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;

    bam_multiplex_display_scanner #(
        .DIGITS (DIGITS),
        .PLANES (PLANES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scanner model state (mirrors the block's reset values)
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]  frame_buf [2][DIGITS][PLANES];
    logic               live_half;     // half currently on the display
    logic [DIGIT_W-1:0] scan_digit;
    logic [PLANE_W-1:0] scan_plane;
    logic [20:0]        slot_hold;     // ticks left in the current slot
    logic [BASE_W-1:0]  base_reg;
    logic [WORD_W-1:0]  dot_reg;

    t_cmd_item cmd_pending[$];   // commands waiting for the driver
    t_slot     slot_expect[$];   // predicted slot starts, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count     = 0;
    int n_taken       = 0;
    int n_slots       = 0;
    int n_dropped     = 0;
    int n_swaps       = 0;
    int n_dot_slots   = 0;

    initial begin
        for (int h = 0; h < 2; h++)
            for (int d = 0; d < DIGITS; d++)
                for (int p = 0; p < PLANES; p++)
                    frame_buf[h][d][p] = '0;
        live_half  = 1'b0;
        scan_digit = '0;
        scan_plane = '0;
        slot_hold  = '0;
        base_reg   = 16'd1;
        dot_reg    = '0;
    end

    // Apply one accepted command to the model; a tick at the end of a slot
    // predicts the word that must come out.
    task automatic scan_step(input t_cmd_item it);
        t_slot       s;
        logic [20:0] span;
        begin
            n_taken++;
            case (it.cmd)
                CMD_WRITE: begin
                    if (it.digit < DIGITS && it.plane < PLANES)
                        frame_buf[~live_half][it.digit][it.plane] = it.word;
                    else
                        n_dropped++;
                end
                CMD_SWAP: begin
                    live_half = ~live_half;
                    n_swaps++;
                end
                CMD_TICK: begin
                    if (slot_hold != 0) begin
                        slot_hold = slot_hold - 1'b1;
                    end else begin
                        s.word = frame_buf[live_half][scan_digit][scan_plane];
                        if (it.blank) begin
                            // blink shows the dot only on the rightmost digit
                            if (it.blink && scan_digit == DIGITS - 1) begin
                                s.word = dot_reg;
                                n_dot_slots++;
                            end else begin
                                s.word = '0;
                            end
                        end
                        s.digit = scan_digit;
                        s.plane = scan_plane;
                        slot_expect.push_back(s);
                        // zero length reloads zero: next tick emits again
                        span      = 21'(base_reg) << scan_plane;
                        slot_hold = (span == 0) ? '0 : span - 1'b1;
                        if (scan_plane == PLANES - 1) begin
                            scan_plane = '0;
                            scan_digit = (scan_digit == DIGITS - 1) ? '0 : scan_digit + 1'b1;
                        end else begin
                            scan_plane = scan_plane + 1'b1;
                        end
                    end
                end
                default: ;  // unused code: no effect
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Command driver: one transfer per accepted handshake, random gaps
    // ------------------------------------------------------------------------
    t_cmd_item on_bus;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                scan_step(on_bus);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = cmd_pending.pop_front();
                    i_s_axis_tdata  <= {7'd0, on_bus.blink, on_bus.blank, on_bus.word,
                                        on_bus.plane, on_bus.digit};
                    i_s_axis_tuser  <= on_bus.cmd;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_slot(input logic [M_TDATA_W-1:0] got);
        t_slot exp_slot;
        begin
            n_slots++;
            if (slot_expect.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, got word %06h digit %0d plane %0d",
                         $time, got[23:0], got[27:24], got[30:28]);
            end else begin
                exp_slot = slot_expect.pop_front();
                if (got[23:0] !== exp_slot.word) begin
                    err_count++;
                    $display("%0t: frame_word mismatch, expected %06h, got %06h",
                             $time, exp_slot.word, got[23:0]);
                end
                if (got[27:24] !== exp_slot.digit) begin
                    err_count++;
                    $display("%0t: digit_now mismatch, expected %0d, got %0d",
                             $time, exp_slot.digit, got[27:24]);
                end
                if (got[30:28] !== exp_slot.plane) begin
                    err_count++;
                    $display("%0t: plane_now mismatch, expected %0d, got %0d",
                             $time, exp_slot.plane, got[30:28]);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_slot(o_m_axis_tdata);
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [DIGIT_W-1:0] digit,
                             input logic [PLANE_W-1:0] plane, input logic [WORD_W-1:0] word,
                             input logic blank, input logic blink);
        t_cmd_item it;
        begin
            it.cmd   = cmd;
            it.digit = digit;
            it.plane = plane;
            it.word  = word;
            it.blank = blank;
            it.blink = blink;
            cmd_pending.push_back(it);
        end
    endtask

    // Mostly ticks and in-range writes; fields not used by a command still
    // carry random values.
    function automatic t_cmd_item random_cmd(input int tick_pct);
        t_cmd_item it;
        int        r;
        begin
            it.digit = DIGIT_W'($urandom_range(15));
            it.plane = PLANE_W'($urandom_range(7));
            r        = $urandom_range(99);
            it.word  = (r < 12) ? '1 : (r < 24) ? '0 : WORD_W'($urandom);
            it.blank = ($urandom_range(99) < 25);
            it.blink = 1'($urandom_range(1));
            r        = $urandom_range(99);
            if (r < tick_pct) begin
                it.cmd = CMD_TICK;
            end else if (r < tick_pct + (100 - tick_pct) * 8 / 10) begin
                it.cmd = CMD_WRITE;
                // a few writes land outside the store and must be dropped
                if ($urandom_range(99) < 88) begin
                    it.digit = DIGIT_W'($urandom_range(DIGITS - 1));
                    it.plane = PLANE_W'($urandom_range(PLANES - 1));
                end
            end else if (r < 97) begin
                it.cmd = CMD_SWAP;
            end else begin
                it.cmd = CMD_UNUSED;
            end
            return it;
        end
    endfunction

    // Wait until every command is taken and every prediction has arrived,
    // then give the pipeline time to go quiet.
    task automatic settle();
        begin
            while (cmd_pending.size() != 0 || i_s_axis_tvalid || slot_expect.size() != 0)
                @(negedge i_clk);
            repeat (PIPE_LAT + 3) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_wdata <= val;
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            case (idx)
                REG_BASE_TICKS:  base_reg = val[BASE_W-1:0];
                REG_DOT_PATTERN: dot_reg  = val[WORD_W-1:0];
                default: ;
            endcase
        end
    endtask

    task automatic run_phase(input int base, input logic [CFG_DATA_W-1:0] dot,
                             input int n_items, input int tx_pct, input int rx_pct);
        begin
            settle();
            write_reg(REG_BASE_TICKS, CFG_DATA_W'(base));
            write_reg(REG_DOT_PATTERN, dot);
            send_idle_pct = tx_pct;
            recv_idle_pct = rx_pct;
            for (int n = 0; n < n_items; n++)
                cmd_pending.push_back(random_cmd(55));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cmd_item it;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_BASE_TICKS, 24'd1);
        write_reg(REG_DOT_PATTERN, 24'h800000);
        send_idle_pct = 16;
        recv_idle_pct = 59;

        // directed: first tick emits from the cleared store, out-of-range
        // writes, the unused code, blink without blank, double swap
        queue_cmd(CMD_TICK,   4'd0,  3'd0, 24'h000000, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE,  4'd0,  3'd0, 24'hFFFFFF, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE,  4'd8,  3'd5, 24'hFFFFFF, 1'b1, 1'b1);
        queue_cmd(CMD_WRITE,  4'd0,  3'd1, 24'hA5A5A5, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE,  4'd9,  3'd0, 24'h123456, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE,  4'd15, 3'd7, 24'hFFFFFF, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE,  4'd0,  3'd6, 24'hABCDEF, 1'b0, 1'b0);
        queue_cmd(CMD_UNUSED, 4'd15, 3'd7, 24'hFFFFFF, 1'b1, 1'b1);
        queue_cmd(CMD_TICK,   4'd0,  3'd0, 24'h000000, 1'b0, 1'b0);
        queue_cmd(CMD_SWAP,   4'd0,  3'd0, 24'h000000, 1'b0, 1'b0);
        queue_cmd(CMD_TICK,   4'd0,  3'd0, 24'h000000, 1'b0, 1'b1);
        queue_cmd(CMD_TICK,   4'd0,  3'd0, 24'h000000, 1'b0, 1'b0);
        queue_cmd(CMD_TICK,   4'd0,  3'd0, 24'h000000, 1'b1, 1'b1);
        queue_cmd(CMD_SWAP,   4'd0,  3'd0, 24'h000000, 1'b0, 1'b0);
        queue_cmd(CMD_SWAP,   4'd0,  3'd0, 24'h000000, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE,  4'd0,  3'd4, 24'h5A5A5A, 1'b0, 1'b0);
        for (int n = 0; n < 8; n++)
            queue_cmd(CMD_TICK, 4'd0, 3'd0, 24'h000000, n[0], 1'b0);

        // random phases, setting and idling vary between them
        run_phase(0, 24'(~0 & $urandom), 250, 16, 59);
        run_phase(1, 24'hFFFFFF,         250, 16, 59);
        run_phase(2, 24'h000000,         250, 59, 16);
        run_phase(3, WORD_W'($urandom),  250, 59, 16);
        run_phase($urandom_range(7, 4), WORD_W'($urandom), 150, 0, 0);

        // longest plane-0 slot: line up on plane 0 with zero-length slots,
        // open one slot at base 65535, then keep ticking inside that slot,
        // where nothing may come out
        settle();
        write_reg(REG_BASE_TICKS, 24'd0);
        while (!(scan_plane == 0 && slot_hold == 0)) begin
            queue_cmd(CMD_TICK, 4'd0, 3'd0, 24'h000000, 1'b0, 1'b0);
            settle();
        end
        write_reg(REG_BASE_TICKS, 24'd65535);
        queue_cmd(CMD_TICK, 4'd3, 3'd2, 24'h000000, 1'b0, 1'b0);
        settle();
        write_reg(REG_BASE_TICKS, 24'd1);
        for (int n = 0; n < 100; n++) begin
            it = random_cmd(97);
            cmd_pending.push_back(it);
        end
        settle();

        repeat (PIPE_LAT + 8) @(posedge i_clk);
        $display("Covered %0d commands (%0d swaps, %0d dropped writes) and %0d slot results,",
                 n_taken, n_swaps, n_dropped, n_slots);
        $display("including %0d blinking dot slots; base_ticks from 0 up to 65535.",
                 n_dot_slots);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit: far beyond the slowest correct run
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results still expected", slot_expect.size());
        $display("Verification failed");
        $finish;
    end

endmodule
